// ----- src/rodt_pkg.sv -----
// ----------------------------------------------------------------------------
// rodt_pkg: shared types and constants for the relay on/off delay timer
// Register map codes and the structs that pass between the top level and
// the per-relay channel logic.
// ----------------------------------------------------------------------------
package rodt_pkg;

  localparam int unsigned DELAY_W = 16;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned MAX_CH  = 2;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_ON_DELAY_A  = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFF_DELAY_A = 3'd1;
  localparam logic [IDX_W-1:0] REG_ON_DELAY_B  = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFF_DELAY_B = 3'd3;
  localparam logic [IDX_W-1:0] REG_ACTIVE_MASK = 3'd4;

  localparam logic [MAX_CH-1:0] ACTIVE_MASK_RESET = 2'b11;

  // per-relay settings
  typedef struct packed {
    logic [DELAY_W-1:0] on_delay;
    logic [DELAY_W-1:0] off_delay;
    logic               level;
  } rodt_chan_cfg_t;

  // control from the top level to each channel
  typedef struct packed {
    logic en;       // process one tick this cycle
    logic started;  // counters already preset
  } rodt_ctrl_t;

  // per-relay result of one tick
  typedef struct packed {
    logic               drive;
    logic               rvalid;
    logic [DELAY_W-1:0] rdelay;
  } rodt_report_t;

endpackage

// ----- src/rodt_chan.sv -----
// ----------------------------------------------------------------------------
// rodt_chan: one relay channel
// Holds the latched request, relay state and both countdowns, and works out
// one tick: switch-on phase, then switch-off phase, then the pin level.
// ----------------------------------------------------------------------------
module rodt_chan (
  input  logic                   clk,
  input  logic                   rst,
  input  rodt_pkg::rodt_ctrl_t   ctrl,
  input  rodt_pkg::rodt_chan_cfg_t cfg,
  input  logic                   request_valid,
  input  logic                   request_bit,
  output rodt_pkg::rodt_report_t report
);
  import rodt_pkg::*;

  logic               req_q;
  logic               relay_on;
  logic [DELAY_W-1:0] on_count;
  logic [DELAY_W-1:0] off_count;

  logic               req;
  logic [DELAY_W-1:0] oc_cur;
  logic [DELAY_W-1:0] fc_cur;
  logic               pend_on;
  logic               pend_off;
  logic               sw_on;
  logic               sw_off;
  logic               on_mid;
  logic [DELAY_W-1:0] fc_mid;
  logic [DELAY_W-1:0] oc_dec;
  logic               req_next;
  logic               relay_on_next;
  logic [DELAY_W-1:0] on_count_next;
  logic [DELAY_W-1:0] off_count_next;

  // tick evaluation
  always_comb begin
    req      = request_valid ? request_bit : req_q;
    // first tick after reset takes the counters straight from the registers
    oc_cur   = ctrl.started ? on_count  : cfg.on_delay;
    fc_cur   = ctrl.started ? off_count : cfg.off_delay;
    pend_on  = req && !relay_on;
    pend_off = !req && relay_on;

    // switch-on phase
    sw_on  = pend_on && (oc_cur == '0);
    oc_dec = (oc_cur != '0) ? oc_cur - DELAY_W'(1) : oc_cur;
    on_mid = relay_on | sw_on;
    fc_mid = sw_on ? cfg.off_delay : fc_cur;

    // switch-off phase; a reloaded off count still ticks down this tick
    sw_off         = !req && on_mid && (fc_mid == '0);
    off_count_next = (!sw_off && fc_mid != '0) ? fc_mid - DELAY_W'(1) : fc_mid;
    on_count_next  = sw_off ? cfg.on_delay : oc_dec;
    relay_on_next  = on_mid & ~sw_off;
    req_next       = req;

    report.rvalid = pend_on | pend_off;
    report.rdelay = pend_on ? oc_cur : (pend_off ? fc_cur : '0);
    report.drive  = relay_on_next ? cfg.level : ~cfg.level;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q    <= 1'b0;
      relay_on <= 1'b0;
    end else if (ctrl.en) begin
      req_q    <= req_next;
      relay_on <= relay_on_next;
    end
  end

  // countdowns, preset on the first tick so no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      on_count  <= on_count_next;
      off_count <= off_count_next;
    end
  end

endmodule

// ----- src/relay_on_off_delay_timer_core.sv -----
// ----------------------------------------------------------------------------
// relay_on_off_delay_timer_core: two-relay on/off delay timer
// Each input beat is one tick with an optional new request pair; each tick
// yields one result beat with pin levels and pending-change reports.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  input   | in_valid/in_stall  | request_valid, request_bits
//  output  | out_valid/out_stall| drive_a/b, report_valid_a/b, report_delay_a/b
//  config  | cfg_we             | cfg_index, cfg_data
//
//  One beat per cycle sustained while the output does not stall; each beat
//  passes the input register, then the tick logic into the result register.
//  The relay state loop closes inside each channel. Reset clears valids,
//  relay states and requests; counters are preset from the delay registers
//  on the first tick. A stalled output holds its beat; the input stalls only
//  when the input register is full and the result register cannot drain.
// ----------------------------------------------------------------------------
module relay_on_off_delay_timer_core #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  // config
  input  logic                             cfg_we,
  input  logic [rodt_pkg::IDX_W-1:0]       cfg_index,
  input  logic [rodt_pkg::DELAY_W-1:0]     cfg_data,
  // input beats
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             request_valid,
  input  logic [rodt_pkg::REQ_W-1:0]       request_bits,
  // output beats
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             drive_a,
  output logic                             drive_b,
  output logic                             report_valid_a,
  output logic [rodt_pkg::DELAY_W-1:0]     report_delay_a,
  output logic                             report_valid_b,
  output logic [rodt_pkg::DELAY_W-1:0]     report_delay_b
);
  import rodt_pkg::*;

  logic [DELAY_W-1:0] on_delay_reg  [MAX_CH];
  logic [DELAY_W-1:0] off_delay_reg [MAX_CH];
  logic [MAX_CH-1:0]  active_mask;

  logic               s1_valid;
  logic               s1_req_valid;
  logic [REQ_W-1:0]   s1_req_bits;
  logic               started;
  logic               out_ready;
  logic               advance;
  rodt_ctrl_t         ctrl;
  rodt_chan_cfg_t     chan_cfg [MAX_CH];
  rodt_report_t       rep      [MAX_CH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      on_delay_reg[0]  <= '0;
      on_delay_reg[1]  <= '0;
      off_delay_reg[0] <= '0;
      off_delay_reg[1] <= '0;
      active_mask      <= ACTIVE_MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_DELAY_A:  on_delay_reg[0]  <= cfg_data;
        REG_OFF_DELAY_A: off_delay_reg[0] <= cfg_data;
        REG_ON_DELAY_B:  on_delay_reg[1]  <= cfg_data;
        REG_OFF_DELAY_B: off_delay_reg[1] <= cfg_data;
        REG_ACTIVE_MASK: active_mask      <= cfg_data[MAX_CH-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req_valid <= request_valid;
      s1_req_bits  <= request_bits;
    end
  end

  // first-tick flag
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (advance) begin
      started <= 1'b1;
    end
  end

  assign ctrl.en      = advance;
  assign ctrl.started = started;

  // relay channels
  for (genvar c = 0; c < MAX_CH; c++) begin : g_ch
    assign chan_cfg[c].on_delay  = on_delay_reg[c];
    assign chan_cfg[c].off_delay = off_delay_reg[c];
    assign chan_cfg[c].level     = active_mask[c];
    if (c < CHANNELS) begin : g_on
      rodt_chan u_chan (
        .clk           (clk),
        .rst           (rst),
        .ctrl          (ctrl),
        .cfg           (chan_cfg[c]),
        .request_valid (s1_req_valid),
        .request_bit   (s1_req_bits[c]),
        .report        (rep[c])
      );
    end else begin : g_off
      assign rep[c] = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_a        <= rep[0].drive;
      drive_b        <= rep[1].drive;
      report_valid_a <= rep[0].rvalid;
      report_delay_a <= rep[0].rdelay;
      report_valid_b <= rep[1].rvalid;
      report_delay_b <= rep[1].rdelay;
    end
  end

`ifndef NO_ASSERTIONS
  // a full input register facing a stalled output must hold off new beats
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input accepted while pipeline is blocked");

  // no pending change means a zero delay report
  a_report_a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid_a |-> report_delay_a == '0)
    else $error("relay A delay reported without pending change");

  // an absent second relay stays silent
  a_chan_b_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (CHANNELS == 1) |-> !drive_b && !report_valid_b)
    else $error("relay B active with one channel configured");

  // counters are preset once only
  a_started_sticky: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("first-tick flag dropped");
`endif

endmodule

// ----- verif/tb_relay_on_off_delay_timer_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_relay_on_off_delay_timer_core: self-checking bench for the relay timer
// Drives tick beats with request pairs through the valid/stall input, holds
// a cycle-free model of both relay channels, and compares every result beat
// field by field. Settings change between phases once the pipe has drained.
// ----------------------------------------------------------------------------
module tb_relay_on_off_delay_timer_core;
  import rodt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_OPENING   = 24;
  localparam int unsigned N_REGS      = 2**IDX_W;

  // expected contents of one result beat
  typedef struct packed {
    logic               drive_a;
    logic               drive_b;
    logic               valid_a;
    logic [DELAY_W-1:0] delay_a;
    logic               valid_b;
    logic [DELAY_W-1:0] delay_b;
  } tick_result_t;

  // --------------------------------------------------------------------------
  // relay timer model and result scoreboard
  // --------------------------------------------------------------------------
  class relay_timer_scoreboard;
    logic [DELAY_W-1:0] on_delay [MAX_CH];
    logic [DELAY_W-1:0] off_delay [MAX_CH];
    logic [MAX_CH-1:0]  level_mask;
    logic               want_on [MAX_CH];
    logic               is_on [MAX_CH];
    logic [DELAY_W-1:0] on_cnt [MAX_CH];
    logic [DELAY_W-1:0] off_cnt [MAX_CH];
    bit                 preset_done;
    tick_result_t       expected_q [$];
    int                 errors;
    int                 ticks;
    int                 compared;
    int                 switches;
    int                 pending_reports;

    function new();
      for (int c = 0; c < MAX_CH; c++) begin
        on_delay[c]  = '0;
        off_delay[c] = '0;
        want_on[c]   = 1'b0;
        is_on[c]     = 1'b0;
        on_cnt[c]    = '0;
        off_cnt[c]   = '0;
      end
      level_mask      = ACTIVE_MASK_RESET;
      preset_done     = 1'b0;
      errors          = 0;
      ticks           = 0;
      compared        = 0;
      switches        = 0;
      pending_reports = 0;
    endfunction

    // mirror of a register write; unknown indexes are dropped
    function void set_reg(logic [IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
      case (idx)
        REG_ON_DELAY_A:  on_delay[0]  = data;
        REG_OFF_DELAY_A: off_delay[0] = data;
        REG_ON_DELAY_B:  on_delay[1]  = data;
        REG_OFF_DELAY_B: off_delay[1] = data;
        REG_ACTIVE_MASK: level_mask   = data[MAX_CH-1:0];
        default: ;
      endcase
    endfunction

    // one accepted tick: advance both relays and queue the expected beat
    function void note_tick(logic rv, logic [REQ_W-1:0] rb);
      logic               rvalid [MAX_CH];
      logic [DELAY_W-1:0] rdelay [MAX_CH];
      logic               drv [MAX_CH];
      tick_result_t       r;
      // counters take the register values on the first tick only
      if (!preset_done) begin
        for (int c = 0; c < MAX_CH; c++) begin
          on_cnt[c]  = on_delay[c];
          off_cnt[c] = off_delay[c];
        end
        preset_done = 1'b1;
      end
      if (rv) begin
        want_on[0] = rb[0];
        want_on[1] = rb[1];
      end
      for (int c = 0; c < MAX_CH; c++) begin
        rvalid[c] = 1'b0;
        rdelay[c] = '0;
        // switch-on phase
        if (want_on[c] && !is_on[c]) begin
          rvalid[c] = 1'b1;
          rdelay[c] = on_cnt[c];
        end
        if (want_on[c] && !is_on[c] && on_cnt[c] == '0) begin
          is_on[c]   = 1'b1;
          off_cnt[c] = off_delay[c];
          switches++;
        end else if (on_cnt[c] != '0) begin
          on_cnt[c] = on_cnt[c] - 1'b1;
        end
        // switch-off phase
        if (!want_on[c] && is_on[c]) begin
          rvalid[c] = 1'b1;
          rdelay[c] = off_cnt[c];
        end
        if (!want_on[c] && is_on[c] && off_cnt[c] == '0) begin
          is_on[c]  = 1'b0;
          on_cnt[c] = on_delay[c];
          switches++;
        end else if (off_cnt[c] != '0) begin
          off_cnt[c] = off_cnt[c] - 1'b1;
        end
        drv[c] = is_on[c] ? level_mask[c] : ~level_mask[c];
        if (rvalid[c]) pending_reports++;
      end
      r.drive_a = drv[0];
      r.drive_b = drv[1];
      r.valid_a = rvalid[0];
      r.delay_a = rdelay[0];
      r.valid_b = rvalid[1];
      r.delay_b = rdelay[1];
      expected_q.push_back(r);
      ticks++;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("ERROR result %0d: %s", compared, what);
    endtask

    // compare one accepted result beat with the oldest expectation
    task check_result(tick_result_t got);
      tick_result_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.drive_a !== exp_r.drive_a)
        report_mismatch($sformatf("drive_a %b, want %b", got.drive_a, exp_r.drive_a));
      if (got.drive_b !== exp_r.drive_b)
        report_mismatch($sformatf("drive_b %b, want %b", got.drive_b, exp_r.drive_b));
      if (got.valid_a !== exp_r.valid_a)
        report_mismatch($sformatf("report_valid_a %b, want %b", got.valid_a, exp_r.valid_a));
      if (got.delay_a !== exp_r.delay_a)
        report_mismatch($sformatf("report_delay_a %0d, want %0d", got.delay_a, exp_r.delay_a));
      if (got.valid_b !== exp_r.valid_b)
        report_mismatch($sformatf("report_valid_b %b, want %b", got.valid_b, exp_r.valid_b));
      if (got.delay_b !== exp_r.delay_b)
        report_mismatch($sformatf("report_delay_b %0d, want %0d", got.delay_b, exp_r.delay_b));
      compared++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_we        = 1'b0;
  logic [IDX_W-1:0]   cfg_index     = '0;
  logic [DELAY_W-1:0] cfg_data      = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               request_valid = 1'b0;
  logic [REQ_W-1:0]   request_bits  = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               drive_a;
  logic               drive_b;
  logic               report_valid_a;
  logic [DELAY_W-1:0] report_delay_a;
  logic               report_valid_b;
  logic [DELAY_W-1:0] report_delay_b;

  relay_timer_scoreboard sb;
  bit                    idle_on = 1'b1;
  int                    stall_left = 0;
  int                    cycle_count = 0;
  int                    settings_count = 0;

  relay_on_off_delay_timer_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .request_valid  (request_valid),
    .request_bits   (request_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_a        (drive_a),
    .drive_b        (drive_b),
    .report_valid_a (report_valid_a),
    .report_delay_a (report_delay_a),
    .report_valid_b (report_valid_b),
    .report_delay_b (report_delay_b)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_q.size());
      $display("relay_on_off_delay_timer_core regression: fail");
      $finish;
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (idle_on && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end
  end

  // result beat monitor
  always @(posedge clk) begin
    tick_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.drive_a = drive_a;
      got.drive_b = drive_b;
      got.valid_a = report_valid_a;
      got.delay_a = report_delay_a;
      got.valid_b = report_valid_b;
      got.delay_b = report_delay_b;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // drivers; each is entered and left at a falling edge
  // --------------------------------------------------------------------------

  // one tick beat, with an optional sender gap in front of it
  task automatic send_tick(input logic rv, input logic [REQ_W-1:0] rb);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_valid      <= 1'b0;
      request_valid <= 1'($urandom);
      request_bits  <= REQ_W'($urandom);
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    request_valid <= rv;
    request_bits  <= rb;
    do @(posedge clk); while (in_stall);
    sb.note_tick(rv, rb);
    @(negedge clk);
  endtask

  // write all registers in turn, plus the unmapped indexes with noise
  task automatic load_settings(input logic [DELAY_W-1:0] on_a, off_a, on_b, off_b,
                               input logic [MAX_CH-1:0] mask);
    logic [DELAY_W-1:0] word [N_REGS];
    for (int i = 0; i < N_REGS; i++) word[i] = DELAY_W'($urandom);
    word[REG_ON_DELAY_A]  = on_a;
    word[REG_OFF_DELAY_A] = off_a;
    word[REG_ON_DELAY_B]  = on_b;
    word[REG_OFF_DELAY_B] = off_b;
    word[REG_ACTIVE_MASK] = {word[REG_ACTIVE_MASK][DELAY_W-1:MAX_CH], mask};
    for (int i = 0; i < N_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= word[i];
      @(negedge clk);
      sb.set_reg(IDX_W'(i), word[i]);
    end
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic random_settings(input int max_delay, input logic [MAX_CH-1:0] mask);
    load_settings(DELAY_W'($urandom_range(0, max_delay)),
                  DELAY_W'($urandom_range(0, max_delay)),
                  DELAY_W'($urandom_range(0, max_delay)),
                  DELAY_W'($urandom_range(0, max_delay)), mask);
  endtask

  // stop sending and wait for every expected beat to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_q.size() != 0);
  endtask

  // request changes held for random spans, with some stray beats mixed in
  task automatic run_requests(input int count, input int hold_max);
    int               sent;
    logic [REQ_W-1:0] want;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(1'($urandom), REQ_W'($urandom));
        sent++;
      end else begin
        want = REQ_W'($urandom);
        send_tick(1'b1, want);
        sent++;
        repeat ($urandom_range(0, hold_max)) begin
          if ($urandom_range(0, 3) == 0) send_tick(1'b1, want);
          else send_tick(1'b0, REQ_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  // opening beats {request_valid, request_bits}: ignored bits, immediate and
  // delayed switches, holding with no new request, both relays together
  logic [REQ_W:0] opening_ticks [N_OPENING] = '{
    3'b011, 3'b101, 3'b000, 3'b111, 3'b010, 3'b001, 3'b000, 3'b011,
    3'b110, 3'b000, 3'b000, 3'b000, 3'b100, 3'b000, 3'b000, 3'b000,
    3'b111, 3'b111, 3'b100, 3'b111, 3'b101, 3'b110, 3'b000, 3'b000
  };

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // these values also preset the counters on the first tick
    load_settings(16'd0, 16'd0, 16'd3, 16'd2, 2'b01);
    foreach (opening_ticks[i]) send_tick(opening_ticks[i][REQ_W], opening_ticks[i][REQ_W-1:0]);
    drain_results();

    random_settings(4, 2'b11);
    run_requests(330, 8);
    drain_results();

    random_settings(12, 2'b00);
    run_requests(330, 20);
    drain_results();

    random_settings(0, MAX_CH'($urandom));
    run_requests(300, 3);
    drain_results();

    random_settings(30, MAX_CH'($urandom));
    run_requests(330, 40);
    drain_results();

    // closing phases at full rate with the widest delays
    idle_on = 1'b0;
    load_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 2'b10);
    run_requests(220, 6);
    drain_results();

    load_settings(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 2'b01);
    run_requests(220, 6);
    drain_results();

    repeat (8) @(negedge clk);
    $display("%0d ticks under %0d register settings, %0d result beats compared",
             sb.ticks, settings_count, sb.compared);
    $display("%0d relay switches, %0d channel reports with a pending change",
             sb.switches, sb.pending_reports);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("relay_on_off_delay_timer_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.expected_q.size());
      $display("relay_on_off_delay_timer_core regression: fail");
    end
    $finish;
  end

endmodule
